[rtl/core/ball_bounce_physics_step_defines.svh]
// Assertion helpers for the bouncing ball core.
`ifndef BALL_BOUNCE_PHYSICS_STEP_DEFINES_SVH
`define BALL_BOUNCE_PHYSICS_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define BBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/bbp_pkg.sv]
`default_nettype none
package bbp_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST_SPEED  = 3'd5;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADT, ST_VDT, ST_ADTDT, ST_UPD,
        ST_SQ, ST_SQRS, ST_CHECK, ST_REST, ST_DONE
    } state_t;

    // mul_sel choices for the shared multiplier
    typedef enum logic [2:0] {
        M_A_DT, M_V_DT, M_ADT_DT, M_V_SQ, M_RS_SQ, M_V_REST
    } mul_sel_t;

    typedef struct packed {
        logic       load;     // take load fields
        logic       clr_acc;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic [1:0] axis;
        logic       upd;      // write pos/vel of axis
        logic       bounce;   // vel_y <= scaled result
        logic       rest;     // stop ball
        logic       out_load; // latch result register
    } cmd_t;

    typedef struct packed {
        logic moving;
        logic hit;       // below plane and falling
        logic fast;      // speed2 above threshold
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'(signed'(Q_MAX))) return Q_MAX;
        if (x < 66'(signed'(Q_MIN))) return Q_MIN;
        return x[31:0];
    endfunction
endpackage
`default_nettype wire

[rtl/core/bbp_if.sv]
`default_nettype none
interface bbp_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic        [16:0] time_step;
    logic signed [31:0] load_pos_x, load_pos_y, load_pos_z;
    logic signed [31:0] load_vel_x, load_vel_y, load_vel_z;
    modport source(output valid, command, time_step, load_pos_x, load_pos_y, load_pos_z,
                   load_vel_x, load_vel_y, load_vel_z, input ready);
    modport sink(input valid, command, time_step, load_pos_x, load_pos_y, load_pos_z,
                 load_vel_x, load_vel_y, load_vel_z, output ready);
endinterface

interface bbp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic               bounced;
    logic               active;
    modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, bounced, active,
                   input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, bounced, active,
                 output ready);
endinterface
`default_nettype wire

[rtl/core/bbp_ctrl.sv]
`default_nettype none
`include "ball_bounce_physics_step_defines.svh"
module bbp_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_command,
    output logic              in_ready,
    input  wire logic         out_free,
    input  wire bbp_pkg::sts_t sts,
    output bbp_pkg::cmd_t     cmd
);
    bbp_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbp_pkg::ST_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == bbp_pkg::ST_IDLE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            bbp_pkg::ST_IDLE:
            begin
                axis_next = 2'd0;
                if (in_valid && in_ready)
                begin
                    if (in_command || !sts.moving) state_next = bbp_pkg::ST_DONE;
                    else                           state_next = bbp_pkg::ST_ADT;
                end
            end
            bbp_pkg::ST_ADT:   state_next = bbp_pkg::ST_VDT;
            bbp_pkg::ST_VDT:   state_next = bbp_pkg::ST_ADTDT;
            bbp_pkg::ST_ADTDT: state_next = bbp_pkg::ST_UPD;
            bbp_pkg::ST_UPD:
            begin
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = sts.hit ? bbp_pkg::ST_SQ : bbp_pkg::ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = bbp_pkg::ST_ADT;
                end
            end
            bbp_pkg::ST_SQ:
            begin
                if (axis_reg == 2'd2) state_next = bbp_pkg::ST_SQRS;
                else                  axis_next = axis_reg + 2'd1;
            end
            bbp_pkg::ST_SQRS:  state_next = bbp_pkg::ST_CHECK;
            bbp_pkg::ST_CHECK: state_next = sts.fast ? bbp_pkg::ST_REST : bbp_pkg::ST_REST;
            bbp_pkg::ST_REST:  state_next = bbp_pkg::ST_DONE;
            bbp_pkg::ST_DONE:  state_next = bbp_pkg::ST_IDLE;
            default:           state_next = bbp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = bbp_pkg::M_A_DT;
        cmd.axis     = axis_reg;
        case (state_reg)
            bbp_pkg::ST_IDLE:
            begin
                cmd.load    = in_valid && in_ready && in_command;
                cmd.clr_acc = 1'b1;
            end
            bbp_pkg::ST_ADT:   begin cmd.mul_en = 1'b1; cmd.mul_sel = bbp_pkg::M_A_DT; end
            bbp_pkg::ST_VDT:   begin cmd.mul_en = 1'b1; cmd.mul_sel = bbp_pkg::M_V_DT; end
            bbp_pkg::ST_ADTDT: begin cmd.mul_en = 1'b1; cmd.mul_sel = bbp_pkg::M_ADT_DT; end
            bbp_pkg::ST_UPD:   cmd.upd = 1'b1;
            bbp_pkg::ST_SQ:    begin cmd.mul_en = 1'b1; cmd.mul_sel = bbp_pkg::M_V_SQ; end
            bbp_pkg::ST_SQRS:  begin cmd.mul_en = 1'b1; cmd.mul_sel = bbp_pkg::M_RS_SQ; end
            bbp_pkg::ST_CHECK: begin cmd.mul_en = 1'b1; cmd.mul_sel = bbp_pkg::M_V_REST; end
            bbp_pkg::ST_REST:
            begin
                cmd.bounce = sts.fast;
                cmd.rest   = !sts.fast;
            end
            bbp_pkg::ST_DONE:  cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    `BBP_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_reg == bbp_pkg::ST_IDLE, "ready outside idle")
    `BBP_ASSERT(a_done_back, clk, rst_n, state_reg == bbp_pkg::ST_DONE |=> state_reg == bbp_pkg::ST_IDLE, "done did not return")
    `BBP_ASSERT(a_axis, clk, rst_n, axis_reg != 2'd3, "axis out of range")
endmodule
`default_nettype wire

[rtl/core/bbp_dp.sv]
`default_nettype none
module bbp_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bbp_pkg::cmd_t      cmd,
    output bbp_pkg::sts_t           sts,
    input  wire logic               take,
    input  wire logic        [16:0] time_step,
    input  wire logic signed [31:0] ld_pos [3],
    input  wire logic signed [31:0] ld_vel [3],
    input  wire logic signed [31:0] accel [3],
    input  wire logic        [16:0] restitution,
    input  wire logic        [30:0] ball_radius,
    input  wire logic        [30:0] rest_speed,
    output logic signed [31:0]      pos [3],
    output logic signed [31:0]      vel [3],
    output logic                    moving
);
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic               moving_reg;
    logic        [16:0] dt_reg;
    logic signed [33:0] adt_reg;        // floor(a*dt/2^16)
    logic signed [65:0] acc_reg;        // 2*v*dt + adt*dt
    logic        [65:0] sq_reg;
    logic        [61:0] rs2_reg;
    logic signed [65:0] prod_reg;
    logic signed [33:0] ma;
    logic signed [33:0] mb;
    logic signed [67:0] prod;

    assign pos    = pos_reg;
    assign vel    = vel_reg;
    assign moving = moving_reg;

    always_comb
    begin
        ma = 34'(signed'(accel[cmd.axis]));
        mb = 34'(signed'({1'b0, dt_reg}));
        case (cmd.mul_sel)
            bbp_pkg::M_A_DT:   ma = 34'(signed'(accel[cmd.axis]));
            bbp_pkg::M_V_DT:   ma = 34'(signed'(vel_reg[cmd.axis]));
            bbp_pkg::M_ADT_DT: ma = adt_reg;
            bbp_pkg::M_V_SQ:
            begin
                ma = 34'(signed'(vel_reg[cmd.axis]));
                mb = ma;
            end
            bbp_pkg::M_RS_SQ:
            begin
                ma = 34'({3'b0, rest_speed});
                mb = ma;
            end
            bbp_pkg::M_V_REST:
            begin
                ma = -34'(signed'(vel_reg[1]));
                mb = 34'({17'b0, restitution});
            end
            default: ;
        endcase
        prod = ma * mb;
    end

    // At most one multiply per state; each product is registered here for use
    // by a later state.
    always_ff @(posedge clk)
    begin
        if (take) dt_reg <= time_step;
        if (cmd.clr_acc) sq_reg <= '0;
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                bbp_pkg::M_A_DT:   adt_reg <= 34'(prod >>> 16);
                bbp_pkg::M_V_DT:   acc_reg <= 66'(prod <<< 1);
                bbp_pkg::M_ADT_DT: acc_reg <= acc_reg + 66'(prod);
                bbp_pkg::M_V_SQ:   sq_reg  <= sq_reg + 66'(prod);
                bbp_pkg::M_RS_SQ:  rs2_reg <= 62'(prod);
                bbp_pkg::M_V_REST: prod_reg <= 66'(prod >>> 16);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            moving_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            pos_reg    <= ld_pos;
            vel_reg    <= ld_vel;
            moving_reg <= 1'b1;
        end
        else if (cmd.upd)
        begin
            pos_reg[cmd.axis] <= bbp_pkg::sat32(66'(signed'(pos_reg[cmd.axis]))
                                               + (acc_reg >>> 17));
            vel_reg[cmd.axis] <= bbp_pkg::sat32(66'(signed'(vel_reg[cmd.axis]))
                                               + 66'(adt_reg));
        end
        else if (cmd.bounce)
        begin
            vel_reg[1] <= bbp_pkg::sat32(prod_reg);
        end
        else if (cmd.rest)
        begin
            for (int i = 0; i < 3; i++) vel_reg[i] <= '0;
            pos_reg[1] <= signed'({1'b0, ball_radius});
            moving_reg <= 1'b0;
        end
    end

    assign sts.moving = moving_reg;
    assign sts.hit  = (33'(signed'(pos_reg[1])) - 33'(signed'({2'b0, ball_radius})) < 0)
                   && vel_reg[1][31];
    assign sts.fast = sq_reg > 66'(rs2_reg);
endmodule
`default_nettype wire

[rtl/core/ball_bounce_physics_step.sv]
`default_nettype none
`include "ball_bounce_physics_step_defines.svh"
// Bouncing ball core, signed Q16.16. A load transaction sets state; a step
// transaction advances an active ball by dt with constant acceleration and
// handles a bounce on y=0. One result per transaction. Load and inactive
// steps skip the multiplier; an active step is bound by the single shared
// 34x34 multiplier that the sequencer walks over each axis. Output is a
// result register; the next transaction is taken once that register is
// free or being drained.
module ball_bounce_physics_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bbp_in_if.sink           in_ch,
    bbp_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic signed [31:0] accel_reg [3];
    logic        [16:0] rest_reg;
    logic        [30:0] radius_reg;
    logic        [30:0] rspeed_reg;
    logic               ovalid_reg;
    logic               bounced_reg;
    logic               take;
    logic               out_free;
    bbp_pkg::cmd_t      cmd;
    bbp_pkg::sts_t      sts;
    logic signed [31:0] ld_pos [3];
    logic signed [31:0] ld_vel [3];
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic               moving;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg[0] <= '0;
            accel_reg[1] <= '0;
            accel_reg[2] <= '0;
            rest_reg     <= 17'd65536;
            radius_reg   <= 31'd65536;
            rspeed_reg   <= 31'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbp_pkg::REG_ACCEL_X:     accel_reg[0] <= cfg_data;
                bbp_pkg::REG_ACCEL_Y:     accel_reg[1] <= cfg_data;
                bbp_pkg::REG_ACCEL_Z:     accel_reg[2] <= cfg_data;
                bbp_pkg::REG_RESTITUTION: rest_reg     <= cfg_data[16:0];
                bbp_pkg::REG_BALL_RADIUS: radius_reg   <= cfg_data[30:0];
                bbp_pkg::REG_REST_SPEED:  rspeed_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign take     = in_ch.valid && in_ch.ready;
    assign out_free = !ovalid_reg || out_ch.ready;
    assign ld_pos   = '{in_ch.load_pos_x, in_ch.load_pos_y, in_ch.load_pos_z};
    assign ld_vel   = '{in_ch.load_vel_x, in_ch.load_vel_y, in_ch.load_vel_z};

    bbp_ctrl u_ctrl (
        .clk, .rst_n, .in_valid(in_ch.valid), .in_command(in_ch.command),
        .in_ready(in_ch.ready), .out_free, .sts, .cmd
    );

    bbp_dp u_dp (
        .clk, .rst_n, .cmd, .sts, .take, .time_step(in_ch.time_step),
        .ld_pos, .ld_vel, .accel(accel_reg), .restitution(rest_reg),
        .ball_radius(radius_reg), .rest_speed(rspeed_reg), .pos, .vel, .moving
    );

    // bounce flag: set by either bounce outcome, cleared per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                      bounced_reg <= 1'b0;
        else if (take)                   bounced_reg <= 1'b0;
        else if (cmd.bounce || cmd.rest) bounced_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)             ovalid_reg <= 1'b0;
        else if (cmd.out_load)  ovalid_reg <= 1'b1;
        else if (out_ch.ready)  ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_ch.pos_x   <= pos[0];
            out_ch.pos_y   <= pos[1];
            out_ch.pos_z   <= pos[2];
            out_ch.vel_x   <= vel[0];
            out_ch.vel_y   <= vel[1];
            out_ch.vel_z   <= vel[2];
            out_ch.bounced <= bounced_reg;
            out_ch.active  <= moving;
        end
    end

    assign out_ch.valid = ovalid_reg;

    `BBP_ASSERT(a_one_out, clk, rst_n, cmd.out_load |-> out_free, "result overwritten")
    `BBP_ASSERT(a_no_take_busy, clk, rst_n, take |=> !in_ch.ready, "second take while busy")
    `BBP_ASSERT(a_hold, clk, rst_n, ovalid_reg && !out_ch.ready |=> $stable(out_ch.pos_y), "result moved")
endmodule
`default_nettype wire
